// ===== rtl/heading_dead_reckoning_defines.svh =====
// Assertion macros shared by the heading_dead_reckoning RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef HEADING_DEAD_RECKONING_DEFINES_SVH
`define HEADING_DEAD_RECKONING_DEFINES_SVH

// Plain property check, disabled while reset is asserted.
`define HDR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define HDR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HDR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/hdr_pkg.sv =====
// Package for heading_dead_reckoning: sequencer states, CORDIC constants and tables.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps

package hdr_pkg;

  localparam int unsigned CORDIC_ITERATIONS_DEF = 16;

  // Field widths
  localparam int unsigned TURN_W = 18;
  localparam int unsigned DIST_W = 24;
  localparam int unsigned POS_W  = 40;
  localparam int unsigned HEAD_W = 17;
  localparam int unsigned HSUM_W = 19;

  // One full turn in Q.8 degrees
  localparam logic [HEAD_W-1:0] FULL_TURN = 17'd92160;

  // Degrees to binary angle: 92160 = 2^11 * 45, so the angle is
  // floor((h * 2^21 + 22) / 45) = quot * 2^21 + FRAC_TBL[h - 45 * quot].
  localparam int unsigned DEG_DIV    = 45;
  localparam int unsigned ROUND_TERM = 22;
  localparam int unsigned FRAC_W     = 21;
  localparam int unsigned QUOT_W     = 11;
  localparam int unsigned REM_W      = $clog2(DEG_DIV);
  // floor(h / 45) = (h * 186414) >> 23, exact for h < 381300
  localparam int unsigned QMUL_W     = 18;
  localparam logic [QMUL_W-1:0] QUOT_MUL = 18'd186414;
  localparam int unsigned QUOT_SHIFT = 23;

  typedef logic [FRAC_W-1:0] frac_tbl_t [DEG_DIV];

  function automatic frac_tbl_t build_frac_tbl();
    frac_tbl_t t;
    for (int r = 0; r < DEG_DIV; r++) begin
      t[r] = FRAC_W'((64'(r) * (64'd1 << FRAC_W) + 64'(ROUND_TERM)) / DEG_DIV);
    end
    return t;
  endfunction

  localparam frac_tbl_t FRAC_TBL = build_frac_tbl();

  // CORDIC datapath
  localparam int unsigned CORD_W  = 34;
  localparam int unsigned TRIG_W  = 32;
  localparam int unsigned PROD_W  = DIST_W + TRIG_W;
  localparam int unsigned STEP_W  = PROD_W - 30;
  localparam int unsigned ATAN_W  = 30;
  localparam int unsigned ATAN_N  = 32;
  localparam int unsigned ATAN_IW = $clog2(ATAN_N);
  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef logic [ATAN_W-1:0] atan_tbl_t [ATAN_N];

  // atan(2^-k) with 2^32 units per turn
  localparam atan_tbl_t ATAN_TBL = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP,
    ST_QUOT,
    ST_BANG,
    ST_LOAD,
    ST_ROTATE,
    ST_MULX,
    ST_MULY,
    ST_ACCY,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/heading_dead_reckoning.sv =====
// Dead-reckoning walker: turn-then-move commands in, saturating position out.
// Depends on hdr_pkg and heading_dead_reckoning_defines.svh.
`timescale 1ns / 1ps
//
// Channel   | Port group          | tdata / tuser contents (lowest bit first)
// ----------+---------------------+---------------------------------------------
// command   | s_axis_* (slave)    | tdata: turn_angle[17:0], move_distance[41:18]
//           |                     | tuser: new_walk
// position  | m_axis_* (master)   | tdata: pos_x[39:0], pos_y[79:40]
//
// The position word of a command is loaded after the accept, once the WRAP, QUOT,
// BANG, LOAD, ROTATE, MULX, MULY, ACCY and DONE states have run, and the next
// command is taken once the block is back in idle; the rotation loop of the shared
// CORDIC stage runs one step per iteration of CORDIC_ITERATIONS, and the heading
// wrap adds or subtracts a full turn up to twice.
// Reset clears the sequencer, heading, position and the output valid; the
// datapath and output word registers are left as they are; no clearing pass.
// A new command is taken once the block is back in idle, even while the last
// position word still waits on m_axis_tready_i; the finished position holds in
// the sequencer until the output register is free.

`include "heading_dead_reckoning_defines.svh"

module heading_dead_reckoning
  import hdr_pkg::*;
#(
  parameter int unsigned CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [47:0]   s_axis_tdata_i,  // turn_angle[17:0], move_distance[41:18], zero pad
  input  logic          s_axis_tuser_i,  // new_walk
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [79:0]   m_axis_tdata_o   // pos_x[39:0], pos_y[79:40]
);

  localparam int unsigned KW = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
  localparam logic [KW-1:0] K_LAST = KW'(CORDIC_ITERATIONS - 1);

  // Sequencer and control state
  state_e               state_q, state_d;
  logic                 m_valid_q, m_valid_d;
  logic [HEAD_W-1:0]    heading_q, heading_d;
  logic signed [POS_W-1:0] pos_x_q, pos_x_d;
  logic signed [POS_W-1:0] pos_y_q, pos_y_d;
  logic [KW-1:0]        k_q, k_d;

  // Datapath registers
  logic signed [HSUM_W-1:0] hsum_q, hsum_d;
  logic [QUOT_W-1:0]        quot_q, quot_d;
  logic [31:0]              bang_q, bang_d;
  logic signed [CORD_W-1:0] cx_q, cx_d, cy_q, cy_d, z_q, z_d;
  logic                     flip_q, flip_d;
  logic signed [DIST_W-1:0] dist_q, dist_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [POS_W-1:0]         out_x_q, out_x_d, out_y_q, out_y_d;

  // Combinational helpers
  logic                     in_acc;
  logic signed [TURN_W-1:0] turn_in;
  logic [HEAD_W+QMUL_W-1:0] qprod;
  logic [HEAD_W-1:0]        rem_full;
  logic [REM_W-1:0]         rem;
  logic [31:0]              neg_ang;
  logic                     quad_flip;
  logic signed [CORD_W-1:0] dxs, dys, atan_v;
  logic signed [CORD_W-1:0] trig_sel;
  logic signed [TRIG_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [STEP_W-1:0] step;
  logic signed [POS_W-1:0]  acc_base;
  logic signed [POS_W:0]    acc_sum;
  logic signed [POS_W-1:0]  acc_sat;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {out_y_q, out_x_q};
  assign turn_in         = s_axis_tdata_i[TURN_W-1:0];

  // Degrees to binary angle pieces
  assign qprod    = heading_q * QUOT_MUL;
  assign rem_full = heading_q - HEAD_W'(17'(quot_q) * 17'(DEG_DIV));
  assign rem      = rem_full[REM_W-1:0];

  // Negate the angle, then fold quadrants 1 and 2 onto the right half-plane
  assign neg_ang   = 32'(33'd0 - 33'(bang_q));
  assign quad_flip = neg_ang[31] ^ neg_ang[30];

  // Shared CORDIC rotation stage
  assign dxs    = cy_q >>> k_q;
  assign dys    = cx_q >>> k_q;
  assign atan_v = CORD_W'(ATAN_TBL[ATAN_IW'(k_q)]);

  // Shared multiplier: sine in MULX, cosine in MULY, undo the fold here
  always_comb begin
    trig_sel = (state_q == ST_MULX) ? cy_q : cx_q;
    if (flip_q) begin
      trig_sel = -trig_sel;
    end
    mul_b = TRIG_W'(trig_sel);
  end

  // Round the Q.38 product half up to Q.8 and accumulate with saturation
  assign prod_rnd = prod_q + PROD_W'(64'd1 << 29);
  assign step     = STEP_W'(prod_rnd >>> 30);
  assign acc_base = (state_q == ST_MULY) ? pos_x_q : pos_y_q;
  assign acc_sum  = (POS_W+1)'(acc_base) + (POS_W+1)'(step);

  always_comb begin
    if (acc_sum[POS_W] != acc_sum[POS_W-1]) begin
      acc_sat = acc_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[POS_W-1:0];
    end
  end

  // Next state and datapath
  always_comb begin
    state_d   = state_q;
    m_valid_d = m_valid_q;
    heading_d = heading_q;
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    k_d       = k_q;
    hsum_d    = hsum_q;
    quot_d    = quot_q;
    bang_d    = bang_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    z_d       = z_q;
    flip_d    = flip_q;
    dist_d    = dist_q;
    prod_d    = prod_q;
    out_x_d   = out_x_q;
    out_y_d   = out_y_q;

    // Drop the output word once taken
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          dist_d = s_axis_tdata_i[TURN_W +: DIST_W];
          if (s_axis_tuser_i) begin
            // New walk: start from the origin facing zero
            pos_x_d = '0;
            pos_y_d = '0;
            hsum_d  = HSUM_W'(turn_in);
          end else begin
            hsum_d = HSUM_W'(turn_in) + HSUM_W'(heading_q);
          end
          state_d = ST_WRAP;
        end
      end
      ST_WRAP: begin
        // One add or subtract of a full turn per cycle until in range
        if (hsum_q[HSUM_W-1]) begin
          hsum_d = hsum_q + HSUM_W'(FULL_TURN);
        end else if (hsum_q >= HSUM_W'(FULL_TURN)) begin
          hsum_d = hsum_q - HSUM_W'(FULL_TURN);
        end else begin
          heading_d = hsum_q[HEAD_W-1:0];
          state_d   = ST_QUOT;
        end
      end
      ST_QUOT: begin
        quot_d  = qprod[QUOT_SHIFT +: QUOT_W];
        state_d = ST_BANG;
      end
      ST_BANG: begin
        bang_d  = {quot_q, {FRAC_W{1'b0}}} + 32'(FRAC_TBL[rem]);
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        flip_d  = quad_flip;
        z_d     = CORD_W'($signed({neg_ang[31] ^ quad_flip, neg_ang[30:0]}));
        cx_d    = CORDIC_GAIN;
        cy_d    = '0;
        k_d     = '0;
        state_d = ST_ROTATE;
      end
      ST_ROTATE: begin
        if (!z_q[CORD_W-1]) begin
          cx_d = cx_q - dxs;
          cy_d = cy_q + dys;
          z_d  = z_q - atan_v;
        end else begin
          cx_d = cx_q + dxs;
          cy_d = cy_q - dys;
          z_d  = z_q + atan_v;
        end
        k_d = k_q + 1'b1;
        if (k_q == K_LAST) begin
          state_d = ST_MULX;
        end
      end
      ST_MULX: begin
        prod_d  = dist_q * mul_b;
        state_d = ST_MULY;
      end
      ST_MULY: begin
        prod_d  = dist_q * mul_b;
        pos_x_d = acc_sat;
        state_d = ST_ACCY;
      end
      ST_ACCY: begin
        pos_y_d = acc_sat;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!m_valid_q || m_axis_tready_i) begin
          out_x_d   = pos_x_q;
          out_y_d   = pos_y_q;
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      heading_q <= '0;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      heading_q <= heading_d;
      pos_x_q   <= pos_x_d;
      pos_y_q   <= pos_y_d;
      k_q       <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hsum_q  <= hsum_d;
    quot_q  <= quot_d;
    bang_q  <= bang_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    z_q     <= z_d;
    flip_q  <= flip_d;
    dist_q  <= dist_d;
    prod_q  <= prod_d;
    out_x_q <= out_x_d;
    out_y_q <= out_y_d;
  end

  // Checks
  `HDR_ASSERT(a_heading_range, clk_i, rst_ni, heading_q < FULL_TURN, "heading out of range")
  `HDR_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !s_axis_tready_o, "accepted while busy")
  `HDR_ASSERT_NXT(a_done_loads, clk_i, rst_ni, (state_q == ST_DONE) && (!m_valid_q || m_axis_tready_i), m_valid_q && (state_q == ST_IDLE), "result not loaded")
  `HDR_ASSERT_IMP(a_valid_from_done, clk_i, rst_ni, $rose(m_valid_q), $past(state_q) == ST_DONE, "result without finished command")

endmodule

// ===== tb/sv/heading_dead_reckoning_tb.sv =====
// Self-checking testbench for the heading_dead_reckoning walker.
// Depends on hdr_pkg and the heading_dead_reckoning RTL; nothing else.
`timescale 1ns / 1ps

module heading_dead_reckoning_tb;
  import hdr_pkg::*;

  // Turns are Q.8 degrees: one full turn is 360 * 256 units.
  localparam int     TURN_Q8     = 92160;
  localparam int     QUARTER_Q8  = 23040;
  localparam int     TURN_LIMIT  = 92159;
  localparam int     DIST_HI     = 8388607;
  localparam int     DIST_LO     = -8388608;
  localparam longint POS_HI      = 64'sd549755813887;
  localparam longint POS_LO      = -64'sd549755813888;
  localparam int     SINCOS_ITER = 16;
  localparam longint SINCOS_GAIN = 64'sd652032874;   // 0.6072529350 in Q30
  localparam longint HALF_Q30    = 64'sd536870912;   // rounds the Q.38 product
  localparam int     DIR_ROWS    = 22;
  // A short straight run at full distance before turning around.
  localparam int     CLIMB_STEPS = 100;
  localparam int     RAND_ITEMS  = 1825;
  localparam int     IDLE_LIMIT  = 2000;
  localparam int     SETTLE      = 40;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } position_t;

  // One directed command; known marks a row whose answer is typed in.
  typedef struct packed {
    logic                     nw;
    logic signed [TURN_W-1:0] turn;
    logic signed [DIST_W-1:0] span;
    logic                     known;
    logic signed [POS_W-1:0]  ex;
    logic signed [POS_W-1:0]  ey;
  } cmd_row_t;

  logic        clk_i;
  logic        rst_ni   = 1'b0;
  logic        s_valid  = 1'b0;
  logic [47:0] s_data   = '0;   // turn_angle[17:0], move_distance[41:18], zero pad
  logic        s_user   = 1'b0; // new_walk
  logic        m_ready  = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [79:0] m_axis_tdata_o;  // pos_x[39:0], pos_y[79:40]

  heading_dead_reckoning dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Walker state as the block should hold it.
  longint    walk_heading = 0;
  longint    walk_x       = 0;
  longint    walk_y       = 0;
  position_t positions_due [$];

  int  errors       = 0;
  int  sent_cmds    = 0;
  int  seen_words   = 0;
  int  walks        = 0;
  int  pinned_words = 0;
  int  burst_left   = 0;
  int  rx_left      = 0;
  int  idle_cycles  = 0;
  bit  tx_free      = 1'b0;  // no sender gaps
  bit  rx_free      = 1'b0;  // receiver never stalls

  // atan(2^-k), 2^32 units per turn
  function automatic longint atan_turn(input int k);
    case (k)
      0:  return 536870912;
      1:  return 316933406;
      2:  return 167458907;
      3:  return 85004756;
      4:  return 42667331;
      5:  return 21354465;
      6:  return 10679838;
      7:  return 5340245;
      8:  return 2670163;
      9:  return 1335087;
      10: return 667544;
      11: return 333772;
      12: return 166886;
      13: return 83443;
      14: return 41722;
      15: return 20861;
      default: return 0;
    endcase
  endfunction

  // Rotation-mode CORDIC on a binary angle; sine and cosine come back in Q30.
  function automatic void cordic_sincos(input logic [31:0] ang, output longint sn,
                                        output longint cs);
    logic   flip;
    longint z, cx, cy, dx, dy;
    // Fold the left half-plane over by half a turn, negate at the end.
    flip = ang[31] ^ ang[30];
    if (flip) ang = ang + 32'h8000_0000;
    z  = longint'($signed(ang));
    cx = SINCOS_GAIN;
    cy = 0;
    for (int k = 0; k < SINCOS_ITER; k++) begin
      dx = cy >>> k;
      dy = cx >>> k;
      if (z >= 0) begin
        cx = cx - dx;
        cy = cy + dy;
        z  = z - atan_turn(k);
      end else begin
        cx = cx + dx;
        cy = cy - dy;
        z  = z + atan_turn(k);
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    sn = cy;
    cs = cx;
  endfunction

  function automatic longint clamp_pos(input longint v);
    if (v > POS_HI) return POS_HI;
    if (v < POS_LO) return POS_LO;
    return v;
  endfunction

  // Turn, then move; returns the position word the block should emit.
  function automatic position_t advance_walk(input logic nw, input int turn, input int span);
    longint      h, sn, cs, step_x, step_y;
    logic [63:0] bang;
    position_t   p;
    if (nw) begin
      walk_heading = 0;
      walk_x       = 0;
      walk_y       = 0;
    end
    h = (walk_heading + turn) % TURN_Q8;
    if (h < 0) h = h + TURN_Q8;
    walk_heading = h;
    // Degrees to binary angle, rounded half up, then negated mod 2^32.
    bang = ((64'(h) << 32) + 64'(TURN_Q8 / 2)) / 64'(TURN_Q8);
    bang = (64'd0 - bang) & 64'hFFFF_FFFF;
    cordic_sincos(bang[31:0], sn, cs);
    step_x = (longint'(span) * sn + HALF_Q30) >>> 30;
    step_y = (longint'(span) * cs + HALF_Q30) >>> 30;
    walk_x = clamp_pos(walk_x + step_x);
    walk_y = clamp_pos(walk_y + step_y);
    p.x = walk_x[POS_W-1:0];
    p.y = walk_y[POS_W-1:0];
    return p;
  endfunction

  // Present one command word and hold it until the block takes it. Between
  // bursts drop valid for a random gap.
  task automatic push_command(input logic nw, input int turn, input int span,
                              input logic known, input position_t typed);
    int        gap;
    position_t predicted;
    if (burst_left == 0) begin
      gap = tx_free ? 0 : $urandom_range(40);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
    end
    s_valid <= 1'b1;
    s_user  <= nw;
    s_data  <= {6'b0, span[DIST_W-1:0], turn[TURN_W-1:0]};
    do @(posedge clk_i); while (!s_axis_tready_o);
    // Taken at this edge: advance the walker model.
    predicted = advance_walk(nw, turn, span);
    positions_due.insert(positions_due.size(), known ? typed : predicted);
    if (predicted.x == POS_HI[POS_W-1:0] || predicted.x == POS_LO[POS_W-1:0] ||
        predicted.y == POS_HI[POS_W-1:0] || predicted.y == POS_LO[POS_W-1:0])
      pinned_words++;
    if (nw) walks++;
    sent_cmds++;
    if (burst_left > 0) burst_left--;
  endtask

  function automatic int random_turn();
    case ($urandom_range(3))
      0: return int'($urandom_range(5120)) - 2560;
      // land on or next to a quadrant boundary
      1: return QUARTER_Q8 * (int'($urandom_range(6)) - 3) + int'($urandom_range(2)) - 1;
      default: return int'($urandom_range(2 * TURN_LIMIT)) - TURN_LIMIT;
    endcase
  endfunction

  function automatic int random_dist();
    case ($urandom_range(3))
      0: return int'($urandom_range(4096)) - 2048;
      1: case ($urandom_range(4))
           0: return DIST_HI;
           1: return DIST_LO;
           2: return 0;
           3: return 1;
           default: return -1;
         endcase
      default: return int'($urandom_range(32'hFF_FFFF)) + DIST_LO;
    endcase
  endfunction

  // Receiver: check each position word against the oldest expectation,
  // stall on its own run-length pattern, and watch for a hung handshake.
  always @(posedge clk_i) begin
    position_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_ready) begin
        got.x = m_axis_tdata_o[39:0];
        got.y = m_axis_tdata_o[79:40];
        seen_words++;
        if (positions_due.size() == 0) begin
          errors++;
          $display("%0t: position word with nothing expected: x %0d y %0d",
                   $time, got.x, got.y);
        end else begin
          want = positions_due.pop_front();
          if (got.x !== want.x) begin
            errors++;
            $display("%0t: pos_x expected %0d actual %0d", $time, want.x, got.x);
          end
          if (got.y !== want.y) begin
            errors++;
            $display("%0t: pos_y expected %0d actual %0d", $time, want.y, got.y);
          end
        end
      end
      if (rx_free) begin
        m_ready <= 1'b1;
      end else if (rx_left == 0) begin
        // Mostly ready runs, with stalls and now and then a long clean stretch.
        case ($urandom_range(7))
          0, 1:    begin m_ready <= 1'b0; rx_left = $urandom_range(40, 1); end
          2:       begin m_ready <= 1'b1; rx_left = $urandom_range(300, 100); end
          default: begin m_ready <= 1'b1; rx_left = $urandom_range(30, 1); end
        endcase
      end else begin
        rx_left--;
      end
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("heading_dead_reckoning_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    cmd_row_t dir_rows [DIR_ROWS];
    position_t typed;
    int        turn, span;
    dir_rows = '{
      '{1'b0, 0,           0,       1'b1, 0, 0},  // first command after reset
      '{1'b0, 0,           256,     1'b0, 0, 0},
      '{1'b0, 0,           DIST_HI, 1'b0, 0, 0},
      '{1'b0, QUARTER_Q8,  DIST_HI, 1'b0, 0, 0},
      '{1'b0, QUARTER_Q8,  DIST_LO, 1'b0, 0, 0},
      '{1'b0, 23039,       DIST_HI, 1'b0, 0, 0},
      '{1'b0, 2,           DIST_HI, 1'b0, 0, 0},
      '{1'b0, TURN_LIMIT,  1,       1'b0, 0, 0},  // turn wraps past a full turn
      '{1'b0, -TURN_LIMIT, -1,      1'b0, 0, 0},
      '{1'b1, 0,           0,       1'b1, 0, 0},  // new walk clears position
      '{1'b0, 11520,       DIST_HI, 1'b0, 0, 0},
      '{1'b0, 46080,       DIST_HI, 1'b0, 0, 0},
      '{1'b0, 69120,       DIST_LO, 1'b0, 0, 0},
      '{1'b0, -1,          4096,    1'b0, 0, 0},
      '{1'b0, 1,           4096,    1'b0, 0, 0},
      '{1'b1, 46080,       0,       1'b1, 0, 0},
      '{1'b0, -QUARTER_Q8, DIST_HI, 1'b0, 0, 0},
      '{1'b1, -TURN_LIMIT, DIST_LO, 1'b0, 0, 0},
      '{1'b0, TURN_LIMIT,  DIST_HI, 1'b0, 0, 0},
      '{1'b1, 12345,       0,       1'b1, 0, 0},
      '{1'b0, 0,           0,       1'b0, 0, 0},
      '{1'b0, 34560,       65535,   1'b0, 0, 0}
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, wraps, quadrant edges, new walks.
    foreach (dir_rows[i]) begin
      typed.x = dir_rows[i].ex;
      typed.y = dir_rows[i].ey;
      push_command(dir_rows[i].nw, int'(dir_rows[i].turn), int'(dir_rows[i].span),
                   dir_rows[i].known, typed);
    end

    // Run straight ahead at full distance back to back, then turn around and back off.
    tx_free = 1'b1;
    rx_free = 1'b1;
    typed   = '0;
    push_command(1'b1, 0, DIST_HI, 1'b0, typed);
    repeat (CLIMB_STEPS) push_command(1'b0, 0, DIST_HI, 1'b0, typed);
    push_command(1'b0, 2 * QUARTER_Q8, DIST_HI, 1'b0, typed);
    push_command(1'b0, 0, DIST_LO, 1'b0, typed);
    tx_free = 1'b0;
    rx_free = 1'b0;

    // Random walks, mostly several commands long.
    repeat (RAND_ITEMS) begin
      turn = random_turn();
      span = random_dist();
      push_command($urandom_range(15) == 0, turn, span, 1'b0, typed);
    end
    s_valid <= 1'b0;

    while (positions_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (positions_due.size() != 0) begin
      errors++;
      $display("%0t: %0d position words never arrived", $time, positions_due.size());
    end
    $display("Ran %0d commands over %0d new walks, %0d position words checked,",
             sent_cmds, walks, seen_words);
    $display("%0d of them at a saturated coordinate; %0d mismatches.", pinned_words, errors);
    if (errors == 0)
      $display("heading_dead_reckoning_tb: clean");
    else
      $display("heading_dead_reckoning_tb: errors");
    $finish;
  end

endmodule
